>>> rtl/core/cpt_pkg.sv
// ----------------------------------------------------------------------------
// cpt_pkg
// shared widths, codes and item structs for the closest point on triangle core
// ----------------------------------------------------------------------------
package cpt_pkg;

    localparam int CW    = 16;  // coordinate, signed q8.8
    localparam int EW    = 17;  // edge and offset vectors
    localparam int DW    = 36;  // dot products
    localparam int HW    = 38;  // sums of dot products
    localparam int WW    = 74;  // det, s, t and divider operands
    localparam int QW    = 17;  // q0.16 fraction including 1.0
    localparam int AW    = 38;  // output accumulator
    localparam int STEPS = 16;  // quotient bits

    localparam logic [QW-1:0] FRAC_ONE = 17'h10000;

    typedef enum logic [1:0] {
        T_ZERO,
        T_LANE,
        T_COMP
    } t_tmode;

    typedef struct packed {
        logic [2:0][CW-1:0] v0;
        logic [2:0][EW-1:0] e0;
        logic [2:0][EW-1:0] e1;
        t_tmode             tmode;
    } t_side;

    typedef struct packed {
        t_side         side;
        logic [WW-1:0] num_a;
        logic [WW-1:0] den_a;
        logic [WW-1:0] num_b;
        logic [WW-1:0] den_b;
    } t_job;

endpackage

>>> rtl/core/closest_point_on_triangle.sv
// ----------------------------------------------------------------------------
// closest_point_on_triangle
// point of a 3d triangle nearest to a query point, signed q8.8
// ----------------------------------------------------------------------------
// usage
//  - a query (point and three vertices) transfers at a clock edge with start
//    high and busy low; a new query may follow every cycle
//  - the result (near point and degenerate flag) is on the o_ ports for one
//    cycle marked by o_strobe; the receiver cannot hold it off
//  - the delay from the accepting edge to the edge that takes the result is the
//    same for every query; throughput is one query per cycle while busy is low
//  - that delay is set by the six front stages, the queue and the 16 step
//    divider pipeline with two closing stages in the back end
//  - busy rises only if the queue between front and back fills, which the
//    free running back end prevents in normal use
//  - reset (synchronous, active low) drops every query in flight and empties
//    the queue; no strobe appears for a dropped query
//  - a zero divisor from a degenerate triangle yields a zero fraction and
//    sets o_degenerate for that result
// ----------------------------------------------------------------------------
module closest_point_on_triangle #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [cpt_pkg::CW-1:0] i_point_x,
    input  logic [cpt_pkg::CW-1:0] i_point_y,
    input  logic [cpt_pkg::CW-1:0] i_point_z,
    input  logic [cpt_pkg::CW-1:0] i_vert0_x,
    input  logic [cpt_pkg::CW-1:0] i_vert0_y,
    input  logic [cpt_pkg::CW-1:0] i_vert0_z,
    input  logic [cpt_pkg::CW-1:0] i_vert1_x,
    input  logic [cpt_pkg::CW-1:0] i_vert1_y,
    input  logic [cpt_pkg::CW-1:0] i_vert1_z,
    input  logic [cpt_pkg::CW-1:0] i_vert2_x,
    input  logic [cpt_pkg::CW-1:0] i_vert2_y,
    input  logic [cpt_pkg::CW-1:0] i_vert2_z,
    output logic                   o_strobe,
    output logic [cpt_pkg::CW-1:0] o_near_x,
    output logic [cpt_pkg::CW-1:0] o_near_y,
    output logic [cpt_pkg::CW-1:0] o_near_z,
    output logic                   o_degenerate
);
    import cpt_pkg::*;

    // accepting edge to result transfer edge
    localparam int LAT    = 26;
    localparam int WARM_W = $clog2(LAT + 1);

    logic               w_accept;
    logic               w_front_vld;
    t_job               w_front_job;
    logic               w_q_vld;
    t_job               w_q_job;
    logic               w_q_full;
    logic [2:0][CW-1:0] w_near;
    logic [WARM_W-1:0]  r_warm;

    assign w_accept = start && !busy;
    assign busy     = w_q_full;

    // front: edge vectors, dot products, det, s, t and region sort
    cpt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_pnt   ({i_point_z, i_point_y, i_point_x}),
        .i_v0    ({i_vert0_z, i_vert0_y, i_vert0_x}),
        .i_v1    ({i_vert1_z, i_vert1_y, i_vert1_x}),
        .i_v2    ({i_vert2_z, i_vert2_y, i_vert2_x}),
        .o_valid (w_front_vld),
        .o_job   (w_front_job)
    );

    // queue decouples the classifier from the divider lanes
    cpt_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_vld),
        .i_data  (w_front_job),
        .o_valid (w_q_vld),
        .o_data  (w_q_job),
        .o_full  (w_q_full)
    );

    // back: two ratio lanes, then v0 + s*e0 + t*e1 with rounding
    cpt_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_q_vld),
        .i_job        (w_q_job),
        .o_strobe     (o_strobe),
        .o_near       (w_near),
        .o_degenerate (o_degenerate)
    );

    assign o_near_x = w_near[0];
    assign o_near_y = w_near[1];
    assign o_near_z = w_near[2];

    // cycles since reset, saturating at the latency
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warm <= '0;
        end else if (r_warm != WARM_W'(LAT)) begin
            r_warm <= r_warm + 1'b1;
        end
    end

`ifndef SYNTHESIS
    a_fixed_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_warm == WARM_W'(LAT)) |-> (o_strobe == $past(w_accept, LAT)))
        else $error("result strobe does not follow transfer by fixed latency");

    a_queue_never_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("queue filled although back end drains every cycle");

    a_flag_with_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_degenerate |-> o_strobe)
        else $error("degenerate flag outside a result transfer");
`endif

endmodule

>>> rtl/core/cpt_front.sv
// ----------------------------------------------------------------------------
// cpt_front
// dot products, determinant and region classification, six stages
// ----------------------------------------------------------------------------
module cpt_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic [2:0][cpt_pkg::CW-1:0]     i_pnt,
    input  logic [2:0][cpt_pkg::CW-1:0]     i_v0,
    input  logic [2:0][cpt_pkg::CW-1:0]     i_v1,
    input  logic [2:0][cpt_pkg::CW-1:0]     i_v2,
    output logic                            o_valid,
    output cpt_pkg::t_job                   o_job
);
    import cpt_pkg::*;

    localparam int PW = 56;
    localparam int SPLIT = 18;

    logic [5:0] r_vld;

    // stage 1
    logic [2:0][CW-1:0]    r1_v0;
    logic signed [EW-1:0]  r1_e0 [3];
    logic signed [EW-1:0]  r1_e1 [3];
    logic signed [EW-1:0]  r1_dv [3];
    // stage 2
    logic [2:0][CW-1:0]    r2_v0;
    logic [2:0][EW-1:0]    r2_e0, r2_e1;
    logic signed [2*EW-1:0] r2_pa [3], r2_pb [3], r2_pc [3], r2_pd [3], r2_pe [3];
    // stage 3
    logic [2:0][CW-1:0]    r3_v0;
    logic [2:0][EW-1:0]    r3_e0, r3_e1;
    logic signed [DW-1:0]  r3_a, r3_b, r3_c, r3_d, r3_e;
    // stage 4: partial products of ac, bb, be, cd, bd, ae
    logic [2:0][CW-1:0]    r4_v0;
    logic [2:0][EW-1:0]    r4_e0, r4_e1;
    logic signed [DW-1:0]  r4_a, r4_b, r4_c, r4_d, r4_e;
    logic signed [PW-1:0]  r4_lo [6];
    logic signed [PW-1:0]  r4_hi [6];
    // stage 5
    logic [2:0][CW-1:0]    r5_v0;
    logic [2:0][EW-1:0]    r5_e0, r5_e1;
    logic signed [DW-1:0]  r5_a, r5_b, r5_c, r5_d, r5_e;
    logic signed [WW-1:0]  r5_det, r5_s, r5_t;
    // stage 6
    t_job                  r6_job;
    t_job                  n6_job;

    logic signed [WW-1:0]  w_prod [6];

    function automatic logic signed [PW-1:0] mul_lo(input logic signed [DW-1:0] x,
                                                    input logic signed [DW-1:0] y);
        logic signed [SPLIT:0] yl;
        yl = $signed({1'b0, y[SPLIT-1:0]});
        return PW'(x) * PW'(yl);
    endfunction

    function automatic logic signed [PW-1:0] mul_hi(input logic signed [DW-1:0] x,
                                                    input logic signed [DW-1:0] y);
        logic signed [DW-SPLIT-1:0] yh;
        yh = $signed(y[DW-1:SPLIT]);
        return PW'(x) * PW'(yh);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r1_v0 <= i_v0;
        for (int k = 0; k < 3; k++) begin
            r1_e0[k] <= $signed({i_v1[k][CW-1], i_v1[k]}) - $signed({i_v0[k][CW-1], i_v0[k]});
            r1_e1[k] <= $signed({i_v2[k][CW-1], i_v2[k]}) - $signed({i_v0[k][CW-1], i_v0[k]});
            r1_dv[k] <= $signed({i_v0[k][CW-1], i_v0[k]}) - $signed({i_pnt[k][CW-1], i_pnt[k]});
        end

        r2_v0 <= r1_v0;
        for (int k = 0; k < 3; k++) begin
            r2_e0[k] <= r1_e0[k];
            r2_e1[k] <= r1_e1[k];
            r2_pa[k] <= r1_e0[k] * r1_e0[k];
            r2_pb[k] <= r1_e0[k] * r1_e1[k];
            r2_pc[k] <= r1_e1[k] * r1_e1[k];
            r2_pd[k] <= r1_e0[k] * r1_dv[k];
            r2_pe[k] <= r1_e1[k] * r1_dv[k];
        end

        r3_v0 <= r2_v0;
        r3_e0 <= r2_e0;
        r3_e1 <= r2_e1;
        r3_a  <= DW'(r2_pa[0]) + DW'(r2_pa[1]) + DW'(r2_pa[2]);
        r3_b  <= DW'(r2_pb[0]) + DW'(r2_pb[1]) + DW'(r2_pb[2]);
        r3_c  <= DW'(r2_pc[0]) + DW'(r2_pc[1]) + DW'(r2_pc[2]);
        r3_d  <= DW'(r2_pd[0]) + DW'(r2_pd[1]) + DW'(r2_pd[2]);
        r3_e  <= DW'(r2_pe[0]) + DW'(r2_pe[1]) + DW'(r2_pe[2]);

        r4_v0 <= r3_v0;
        r4_e0 <= r3_e0;
        r4_e1 <= r3_e1;
        r4_a  <= r3_a;
        r4_b  <= r3_b;
        r4_c  <= r3_c;
        r4_d  <= r3_d;
        r4_e  <= r3_e;
        r4_lo[0] <= mul_lo(r3_a, r3_c);
        r4_hi[0] <= mul_hi(r3_a, r3_c);
        r4_lo[1] <= mul_lo(r3_b, r3_b);
        r4_hi[1] <= mul_hi(r3_b, r3_b);
        r4_lo[2] <= mul_lo(r3_b, r3_e);
        r4_hi[2] <= mul_hi(r3_b, r3_e);
        r4_lo[3] <= mul_lo(r3_c, r3_d);
        r4_hi[3] <= mul_hi(r3_c, r3_d);
        r4_lo[4] <= mul_lo(r3_b, r3_d);
        r4_hi[4] <= mul_hi(r3_b, r3_d);
        r4_lo[5] <= mul_lo(r3_a, r3_e);
        r4_hi[5] <= mul_hi(r3_a, r3_e);

        r5_v0  <= r4_v0;
        r5_e0  <= r4_e0;
        r5_e1  <= r4_e1;
        r5_a   <= r4_a;
        r5_b   <= r4_b;
        r5_c   <= r4_c;
        r5_d   <= r4_d;
        r5_e   <= r4_e;
        r5_det <= w_prod[0] - w_prod[1];
        r5_s   <= w_prod[2] - w_prod[3];
        r5_t   <= w_prod[4] - w_prod[5];

        r6_job <= n6_job;
    end

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            w_prod[k] = (WW'(r4_hi[k]) <<< SPLIT) + WW'(r4_lo[k]);
        end
    end

    // region classification
    logic signed [WW-1:0] w_st;
    logic signed [HW-1:0] w_ce, w_bd, w_ad, w_be, w_hnum, w_hden, w_negd, w_nege;
    logic                 w_lt, w_sneg, w_tneg;

    always_comb begin
        w_st   = r5_s + r5_t;
        w_lt   = w_st < r5_det;
        w_sneg = r5_s[WW-1];
        w_tneg = r5_t[WW-1];
        w_ce   = HW'(r5_c) + HW'(r5_e);
        w_bd   = HW'(r5_b) + HW'(r5_d);
        w_ad   = HW'(r5_a) + HW'(r5_d);
        w_be   = HW'(r5_b) + HW'(r5_e);
        w_hnum = w_ce - w_bd;
        w_hden = HW'(r5_a) - (HW'(r5_b) <<< 1) + HW'(r5_c);
        w_negd = -HW'(r5_d);
        w_nege = -HW'(r5_e);

        n6_job.side.v0    = r5_v0;
        n6_job.side.e0    = r5_e0;
        n6_job.side.e1    = r5_e1;
        n6_job.side.tmode = T_ZERO;
        n6_job.num_a      = '0;
        n6_job.den_a      = WW'(1);
        n6_job.num_b      = '0;
        n6_job.den_b      = WW'(1);

        if (w_lt) begin
            if (w_sneg) begin
                if (w_tneg && r5_d[DW-1]) begin
                    n6_job.num_a = WW'(w_negd);
                    n6_job.den_a = WW'(r5_a);
                end else begin
                    n6_job.num_b      = WW'(w_nege);
                    n6_job.den_b      = WW'(r5_c);
                    n6_job.side.tmode = T_LANE;
                end
            end else if (w_tneg) begin
                n6_job.num_a = WW'(w_negd);
                n6_job.den_a = WW'(r5_a);
            end else begin
                // interior
                n6_job.num_a      = r5_s;
                n6_job.den_a      = r5_det;
                n6_job.num_b      = r5_t;
                n6_job.den_b      = r5_det;
                n6_job.side.tmode = T_LANE;
            end
        end else begin
            if (w_sneg && !(w_ce > w_bd)) begin
                n6_job.num_b      = WW'(w_nege);
                n6_job.den_b      = WW'(r5_c);
                n6_job.side.tmode = T_LANE;
            end else if (!w_sneg && w_tneg && !(w_ad > w_be)) begin
                n6_job.num_a = WW'(w_negd);
                n6_job.den_a = WW'(r5_a);
            end else begin
                // hypotenuse edge
                n6_job.num_a      = WW'(w_hnum);
                n6_job.den_a      = WW'(w_hden);
                n6_job.side.tmode = T_COMP;
            end
        end
    end

    assign o_valid = r_vld[5];
    assign o_job   = r6_job;

endmodule

>>> rtl/core/cpt_fifo.sv
// ----------------------------------------------------------------------------
// cpt_fifo
// short queue of classified items between front and back
// ----------------------------------------------------------------------------
module cpt_fifo #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cpt_pkg::t_job i_data,
    output logic          o_valid,
    output cpt_pkg::t_job o_data,
    output logic          o_full
);
    import cpt_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             w_push, w_pop;

    // the back end never stalls, so the head leaves in every cycle that the queue is not empty
    assign w_push  = i_push && (r_cnt != CNT_W'(DEPTH));
    assign w_pop   = r_cnt != '0;
    assign o_valid = w_pop;
    assign o_data  = r_mem[r_rd];
    assign o_full  = r_cnt == CNT_W'(DEPTH);

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CNT_W'(w_push) - CNT_W'(w_pop);
        end
    end

endmodule

>>> rtl/core/cpt_div.sv
// ----------------------------------------------------------------------------
// cpt_div
// clamped q0.16 ratio, one restoring step per stage
// ----------------------------------------------------------------------------
module cpt_div (
    input  logic                   i_clk,
    input  logic [cpt_pkg::WW-1:0] i_num,
    input  logic [cpt_pkg::WW-1:0] i_den,
    output logic [cpt_pkg::QW-1:0] o_q,
    output logic                   o_deg
);
    import cpt_pkg::*;

    logic [WW-1:0] r_rem  [STEPS+1];
    logic [WW-1:0] r_den  [STEPS+1];
    logic [QW-1:0] r_q    [STEPS+1];
    logic          r_done [STEPS+1];
    logic          r_deg  [STEPS+1];

    logic [WW-1:0] n_rem [STEPS];
    logic [QW-1:0] n_q   [STEPS];
    logic          w_ge  [STEPS];

    always_comb begin
        for (int i = 0; i < STEPS; i++) begin
            w_ge[i]  = (r_rem[i] << 1) >= r_den[i];
            if (r_done[i]) begin
                n_rem[i] = r_rem[i];
                n_q[i]   = r_q[i];
            end else begin
                n_rem[i] = w_ge[i] ? (r_rem[i] << 1) - r_den[i] : (r_rem[i] << 1);
                n_q[i]   = {r_q[i][QW-2:0], w_ge[i]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        // early outs: zero divisor, nonpositive numerator, numerator at or above the divisor
        r_rem[0] <= i_num;
        r_den[0] <= i_den;
        if (i_den == '0) begin
            r_q[0]    <= '0;
            r_deg[0]  <= 1'b1;
            r_done[0] <= 1'b1;
        end else if ($signed(i_num) <= 0) begin
            r_q[0]    <= '0;
            r_deg[0]  <= 1'b0;
            r_done[0] <= 1'b1;
        end else if ($signed(i_num) >= $signed(i_den)) begin
            r_q[0]    <= FRAC_ONE;
            r_deg[0]  <= 1'b0;
            r_done[0] <= 1'b1;
        end else begin
            r_q[0]    <= '0;
            r_deg[0]  <= 1'b0;
            r_done[0] <= 1'b0;
        end

        for (int i = 0; i < STEPS; i++) begin
            r_rem[i+1]  <= n_rem[i];
            r_den[i+1]  <= r_den[i];
            r_q[i+1]    <= n_q[i];
            r_done[i+1] <= r_done[i];
            r_deg[i+1]  <= r_deg[i];
        end
    end

    assign o_q   = r_q[STEPS];
    assign o_deg = r_deg[STEPS];

endmodule

>>> rtl/core/cpt_back.sv
// ----------------------------------------------------------------------------
// cpt_back
// two divider lanes, interpolation and saturation of the result
// ----------------------------------------------------------------------------
module cpt_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  cpt_pkg::t_job               i_job,
    output logic                        o_strobe,
    output logic [2:0][cpt_pkg::CW-1:0] o_near,
    output logic                        o_degenerate
);
    import cpt_pkg::*;

    localparam int MW = QW + EW + 1;
    localparam logic signed [AW-1:0] HALF   = AW'(32768);
    localparam logic signed [AW-1:0] SAT_HI = AW'(32767);
    localparam logic signed [AW-1:0] SAT_LO = -AW'(32768);

    logic [QW-1:0] w_qa, w_qb;
    logic          w_dega, w_degb;

    cpt_div u_div_a (
        .i_clk (i_clk),
        .i_num (i_job.num_a),
        .i_den (i_job.den_a),
        .o_q   (w_qa),
        .o_deg (w_dega)
    );

    cpt_div u_div_b (
        .i_clk (i_clk),
        .i_num (i_job.num_b),
        .i_den (i_job.den_b),
        .o_q   (w_qb),
        .o_deg (w_degb)
    );

    logic [STEPS:0] r_vld;
    t_side          r_sd [STEPS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[STEPS-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_sd[0] <= i_job.side;
        for (int i = 0; i < STEPS; i++) begin
            r_sd[i+1] <= r_sd[i];
        end
    end

    // products of the fractions with the edges
    logic [QW-1:0]        w_tp;
    logic                 r_m_vld;
    logic                 r_m_deg;
    logic [2:0][CW-1:0]   r_m_v0;
    logic signed [MW-1:0] r_m_ps [3];
    logic signed [MW-1:0] r_m_pt [3];

    always_comb begin
        case (r_sd[STEPS].tmode)
            T_LANE:  w_tp = w_qb;
            T_COMP:  w_tp = FRAC_ONE - w_qa;
            default: w_tp = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else begin
            r_m_vld <= r_vld[STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_deg <= w_dega | w_degb;
        r_m_v0  <= r_sd[STEPS].v0;
        for (int k = 0; k < 3; k++) begin
            r_m_ps[k] <= $signed({1'b0, w_qa}) * $signed(r_sd[STEPS].e0[k]);
            r_m_pt[k] <= $signed({1'b0, w_tp}) * $signed(r_sd[STEPS].e1[k]);
        end
    end

    // q14.24 sum, round half up, floor shift, saturate
    logic signed [AW-1:0] w_acc [3];
    logic signed [AW-1:0] w_qs  [3];
    logic [2:0][CW-1:0]   n_near;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_acc[k] = (AW'($signed(r_m_v0[k])) <<< 16) + AW'(r_m_ps[k]) + AW'(r_m_pt[k])
                       + HALF;
            w_qs[k]  = w_acc[k] >>> 16;
            if (w_qs[k] > SAT_HI) begin
                n_near[k] = SAT_HI[CW-1:0];
            end else if (w_qs[k] < SAT_LO) begin
                n_near[k] = SAT_LO[CW-1:0];
            end else begin
                n_near[k] = w_qs[k][CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe     <= 1'b0;
            o_degenerate <= 1'b0;
        end else begin
            o_strobe     <= r_m_vld;
            o_degenerate <= r_m_vld & r_m_deg;
        end
    end

    always_ff @(posedge i_clk) begin
        o_near <= n_near;
    end

endmodule

>>> tb/closest_point_on_triangle_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// closest_point_on_triangle_tb
// self-checking bench: directed region and corner queries, then random
// triangles; a scoreboard predicts every near point in fixed point and
// compares each strobed result in order
// ----------------------------------------------------------------------------

typedef struct {
    shortint p[3];
    shortint v0[3];
    shortint v1[3];
    shortint v2[3];
} query_t;

typedef struct {
    shortint x;
    shortint y;
    shortint z;
    bit      degen;
} near_t;

typedef logic signed [79:0] wide_t;

class near_point_board;
    near_t expected_q[$];
    int    failures = 0;

    // clamped q0.16 ratio, zero divisor flags degenerate
    function longint ratio(wide_t num, wide_t den, inout bit degen);
        wide_t  r;
        longint q;
        q = 0;
        if (den == 0) begin
            degen = 1'b1;
            return 0;
        end
        if (num <= 0) return 0;
        if (num >= den) return 65536;
        r = num;
        for (int i = 0; i < 16; i++) begin
            r = r <<< 1;
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q = q | 1;
            end
        end
        return q;
    endfunction

    function shortint blend(longint base, longint sp, longint tp, longint e0, longint e1);
        longint acc;
        acc = base * 65536 + sp * e0 + tp * e1 + 32768;
        acc = acc >>> 16;
        if (acc > 32767) acc = 32767;
        if (acc < -32768) acc = -32768;
        return shortint'(acc);
    endfunction

    function void note(query_t q);
        longint e0[3], e1[3], dv[3];
        longint a, b, c, d, e, sp, tp;
        wide_t  det, s, t, den;
        bit     degen;
        near_t  n;
        shortint res[3];
        a = 0; b = 0; c = 0; d = 0; e = 0; degen = 1'b0;
        for (int k = 0; k < 3; k++) begin
            e0[k] = longint'(q.v1[k]) - longint'(q.v0[k]);
            e1[k] = longint'(q.v2[k]) - longint'(q.v0[k]);
            dv[k] = longint'(q.v0[k]) - longint'(q.p[k]);
            a += e0[k] * e0[k];
            b += e0[k] * e1[k];
            c += e1[k] * e1[k];
            d += e0[k] * dv[k];
            e += e1[k] * dv[k];
        end
        det = wide_t'(a) * wide_t'(c) - wide_t'(b) * wide_t'(b);
        s   = wide_t'(b) * wide_t'(e) - wide_t'(c) * wide_t'(d);
        t   = wide_t'(b) * wide_t'(d) - wide_t'(a) * wide_t'(e);
        den = wide_t'(a - 2 * b + c);
        if (s + t < det) begin
            if (s < 0) begin
                if (t < 0 && d < 0) begin
                    sp = ratio(wide_t'(-d), wide_t'(a), degen); tp = 0;
                end else begin
                    sp = 0; tp = ratio(wide_t'(-e), wide_t'(c), degen);
                end
            end else if (t < 0) begin
                sp = ratio(wide_t'(-d), wide_t'(a), degen); tp = 0;
            end else begin
                sp = ratio(s, det, degen);
                tp = ratio(t, det, degen);
            end
        end else begin
            if (s < 0) begin
                if (c + e > b + d) begin
                    sp = ratio(wide_t'(c + e - b - d), den, degen); tp = 65536 - sp;
                end else begin
                    sp = 0; tp = ratio(wide_t'(-e), wide_t'(c), degen);
                end
            end else if (t < 0) begin
                if (a + d > b + e) begin
                    sp = ratio(wide_t'(c + e - b - d), den, degen); tp = 65536 - sp;
                end else begin
                    sp = ratio(wide_t'(-d), wide_t'(a), degen); tp = 0;
                end
            end else begin
                sp = ratio(wide_t'(c + e - b - d), den, degen); tp = 65536 - sp;
            end
        end
        for (int k = 0; k < 3; k++)
            res[k] = blend(longint'(q.v0[k]), sp, tp, e0[k], e1[k]);
        n.x = res[0]; n.y = res[1]; n.z = res[2]; n.degen = degen;
        expected_q.push_back(n);
    endfunction

    function void check(near_t got);
        near_t w;
        if (expected_q.size() == 0) begin
            $error("result with no query outstanding");
            failures++;
            return;
        end
        w = expected_q.pop_front();
        if (got.x != w.x) begin
            $error("near_x expected %0d actual %0d", w.x, got.x); failures++;
        end
        if (got.y != w.y) begin
            $error("near_y expected %0d actual %0d", w.y, got.y); failures++;
        end
        if (got.z != w.z) begin
            $error("near_z expected %0d actual %0d", w.z, got.z); failures++;
        end
        if (got.degen != w.degen) begin
            $error("degenerate expected %0d actual %0d", w.degen, got.degen); failures++;
        end
    endfunction
endclass

module closest_point_on_triangle_tb;

    localparam int LATENCY    = 26;
    localparam int WDOG_LIMIT = 2000;
    localparam int N_RANDOM   = 530;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        o_strobe;
    logic [15:0] o_near_x, o_near_y, o_near_z;
    logic        o_degenerate;
    query_t      drv;

    near_point_board board;
    int              quiet_cycles;

    closest_point_on_triangle dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_point_x    (drv.p[0]),
        .i_point_y    (drv.p[1]),
        .i_point_z    (drv.p[2]),
        .i_vert0_x    (drv.v0[0]),
        .i_vert0_y    (drv.v0[1]),
        .i_vert0_z    (drv.v0[2]),
        .i_vert1_x    (drv.v1[0]),
        .i_vert1_y    (drv.v1[1]),
        .i_vert1_z    (drv.v1[2]),
        .i_vert2_x    (drv.v2[0]),
        .i_vert2_y    (drv.v2[1]),
        .i_vert2_z    (drv.v2[2]),
        .o_strobe     (o_strobe),
        .o_near_x     (o_near_x),
        .o_near_y     (o_near_y),
        .o_near_z     (o_near_z),
        .o_degenerate (o_degenerate)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // monitor: query and result transfers sampled at the rising edge,
    // watchdog counts edges with no transfer at all
    always @(posedge i_clk) begin
        near_t got;
        if (i_rst_n) begin
            if (start && !busy) board.note(drv);
            if (o_strobe) begin
                got.x = o_near_x; got.y = o_near_y; got.z = o_near_z;
                got.degen = o_degenerate;
                board.check(got);
            end
            if ((start && !busy) || o_strobe) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WDOG_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // hold one query on the ports until it transfers
    task automatic send_query(query_t q);
        bit taken;
        @(negedge i_clk);
        drv   <= q;
        start <= 1'b1;
        do begin
            @(posedge i_clk);
            taken = !busy;
        end while (!taken);
    endtask

    task automatic idle_for(int n);
        repeat (n) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    function automatic query_t make_query(shortint px, shortint py, shortint pz,
                                          shortint ax, shortint ay, shortint az,
                                          shortint bx, shortint by, shortint bz,
                                          shortint cx, shortint cy, shortint cz);
        query_t q;
        q.p  = '{px, py, pz};
        q.v0 = '{ax, ay, az};
        q.v1 = '{bx, by, bz};
        q.v2 = '{cx, cy, cz};
        return q;
    endfunction

    // coordinate: full range, or a narrow window so triangles are well formed
    function automatic shortint pick_coord(bit wide_range);
        if (wide_range) return shortint'($urandom_range(0, 65535));
        return shortint'(int'($urandom_range(0, 4095)) - 2048);
    endfunction

    function automatic query_t random_query();
        query_t q;
        int     kind;
        bit     wide_range;
        kind = $urandom_range(0, 9);
        wide_range = (kind < 2);
        for (int k = 0; k < 3; k++) begin
            q.p[k]  = pick_coord(wide_range);
            q.v0[k] = pick_coord(wide_range);
            q.v1[k] = pick_coord(wide_range);
            q.v2[k] = pick_coord(wide_range);
        end
        // collapsed triangles exercise the zero divisor handling
        case (kind)
            2: q.v1 = q.v0;
            3: q.v2 = q.v0;
            4: q.v2 = q.v1;
            default: ;
        endcase
        return q;
    endfunction

    initial begin
        query_t dq[$];
        board        = new();
        quiet_cycles = 0;
        start        = 1'b0;
        drv          = make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        i_rst_n      = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // unit right triangle in the xy plane, point swept over every region
        dq.push_back(make_query(64, 64, 100, 0, 0, 0, 256, 0, 0, 0, 256, 0));     // interior
        dq.push_back(make_query(-100, -100, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0));   // vertex v0
        dq.push_back(make_query(400, -50, 9, 0, 0, 0, 256, 0, 0, 0, 256, 0));     // vertex v1
        dq.push_back(make_query(-50, 400, -9, 0, 0, 0, 256, 0, 0, 0, 256, 0));    // vertex v2
        dq.push_back(make_query(100, -80, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0));     // edge t zero
        dq.push_back(make_query(-80, 100, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0));     // edge s zero
        dq.push_back(make_query(200, 200, 30, 0, 0, 0, 256, 0, 0, 0, 256, 0));    // hypotenuse
        dq.push_back(make_query(300, -10, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0));     // beyond, t<0
        dq.push_back(make_query(-10, 300, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0));     // beyond, s<0
        dq.push_back(make_query(0, 0, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0));         // on a vertex
        // degenerate: point triangle and collinear vertices
        dq.push_back(make_query(10, 20, 30, 5, 5, 5, 5, 5, 5, 5, 5, 5));
        dq.push_back(make_query(10, 20, 30, 0, 0, 0, 100, 100, 100, 200, 200, 200));
        dq.push_back(make_query(10, 20, 30, 0, 0, 0, 0, 0, 0, 256, 0, 0));
        // field extremes
        dq.push_back(make_query(-32768, -32768, -32768, -32768, -32768, -32768,
                                -32768, -32768, -32768, -32768, -32768, -32768));
        dq.push_back(make_query(32767, 32767, 32767, 32767, 32767, 32767,
                                32767, 32767, 32767, 32767, 32767, 32767));
        dq.push_back(make_query(32767, -32768, 32767, -32768, -32768, -32768,
                                32767, -32768, -32768, -32768, 32767, 32767));
        dq.push_back(make_query(-32768, 32767, -32768, 32767, 32767, 32767,
                                -32768, 32767, 32767, 32767, -32768, -32768));
        dq.push_back(make_query(32767, 32767, -32768, -32768, 32767, -32768,
                                32767, -32768, 32767, -1, -1, 0));
        foreach (dq[i]) send_query(dq[i]);

        for (int n = 0; n < N_RANDOM; n++) begin
            send_query(random_query());
            // quiet tail with back to back queries
            if (n < N_RANDOM - 100 && $urandom_range(0, 3) == 0)
                idle_for($urandom_range(1, 18));
            // drain the pipe once mid run
            if (n == N_RANDOM / 2) begin
                idle_for(1);
                while (board.expected_q.size() != 0) @(posedge i_clk);
            end
        end
        idle_for(1);

        while (board.expected_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);

        if (board.failures == 0 && board.expected_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> closest_point_on_triangle.f
rtl/core/cpt_pkg.sv
rtl/core/cpt_front.sv
rtl/core/cpt_fifo.sv
rtl/core/cpt_div.sv
rtl/core/cpt_back.sv
rtl/core/closest_point_on_triangle.sv
tb/closest_point_on_triangle_tb.sv
